// File: hw/rtl/fed_pkg.sv
// Shared types, codes and constants of the flag/escape deframer with CRC-16 check.
package fed_pkg;

    // Frame and escape characters on the serial line.
    localparam logic [7:0] FLAG_BYTE   = 8'h7e;
    localparam logic [7:0] ESC_BYTE    = 8'h7d;
    localparam logic [7:0] ESC_OF_ESC  = 8'h5d;
    localparam logic [7:0] ESC_OF_FLAG = 8'h5e;

    // Frame store depth and register defaults.
    localparam int unsigned MAX_FRAME_DEF = 64;
    localparam logic [6:0]  MIN_LEN_RST   = 7'd6;
    localparam logic [6:0]  MIN_LEN_FLOOR = 7'd3;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DATA = 3'd0,
        ST_CRC  = 3'd1,
        ST_FORM = 3'd2,
        ST_READ = 3'd3,
        ST_OVER = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CRC,
        S_CHK1,
        S_CHK2,
        S_REPLAY,
        S_EMIT
    } t_state;

    // What the decoded input transaction asks for.
    typedef enum logic [3:0] {
        A_READ_ERR,
        A_OVER,
        A_CHECK,
        A_DROP,
        A_IGNORE,
        A_FORM,
        A_ESC,
        A_FULL,
        A_STORE,
        A_STORE_CRC
    } t_action;

    // Frame store read address select.
    typedef enum logic [1:0] {
        RD_FILL1,
        RD_FILL2,
        RD_NEXT
    } t_rd_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_in;
        logic    store;
        logic    ovf_set;
        logic    crc_upd;
        logic    esc_set;
        logic    esc_clr;
        logic    rcv_clr;
        logic    frame_clr;
        logic    hi_cap;
        logic    idx_clr;
        logic    idx_inc;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic failed;
        logic is_flag;
        logic is_esc;
        logic esc_ok;
        logic esc_pending;
        logic receiving;
        logic overflowed;
        logic full;
        logic ge2;
        logic long_enough;
        logic crc_match;
        logic idx_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: hw/rtl/fed_if.sv
// Valid/ready channel interfaces for received bytes and for results.
interface fed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       read_failed;

    modport source (output valid, output rx_byte, output read_failed, input ready);
    modport sink   (input valid, input rx_byte, input read_failed, output ready);
endinterface

interface fed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output data_byte, output status, output last, input ready);
    modport sink   (input valid, input data_byte, input status, input last, output ready);
endinterface

// File: hw/rtl/fed_dpath.sv
// Datapath: input latch, frame store, CRC-16 register, replay index and output register.
module fed_dpath #(
    parameter int unsigned MAX_FRAME = fed_pkg::MAX_FRAME_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_data,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_read_failed,
    input  fed_pkg::t_dp_cmd  i_cmd,
    output fed_pkg::t_dp_stat o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_data_byte,
    output logic [2:0]        o_status,
    output logic              o_last
);
    localparam int unsigned AW = $clog2(MAX_FRAME);
    localparam logic [AW:0] FILL_MAX = (AW + 1)'(MAX_FRAME);

    // Byte-wise CRC-16/CCITT update.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]};
        c = c ^ {8'h00, b};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

    logic [6:0]    r_min_len;
    logic [7:0]    r_in_byte;
    logic          r_in_failed;
    logic [AW:0]   r_fill;
    logic          r_receiving;
    logic          r_esc;
    logic          r_ovf;
    logic [15:0]   r_crc;
    logic [7:0]    r_hi;
    logic [AW-1:0] r_idx;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_mem [MAX_FRAME];
    logic          r_out_valid;
    logic [7:0]    r_out_data;
    logic [2:0]    r_out_status;
    logic          r_out_last;

    logic [7:0]    store_byte;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] n_idx;
    logic [6:0]    need;
    logic          out_free;

    // Escaped bytes map back to the flag or escape character.
    always_comb begin
        if (r_esc) begin
            store_byte = (r_in_byte == fed_pkg::ESC_OF_ESC) ? fed_pkg::ESC_BYTE
                                                            : fed_pkg::FLAG_BYTE;
        end else begin
            store_byte = r_in_byte;
        end
    end

    // Replay index and read address selection.
    always_comb begin
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + AW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            fed_pkg::RD_FILL1: rd_addr = AW'(r_fill - (AW + 1)'(1));
            fed_pkg::RD_FILL2: rd_addr = AW'(r_fill - (AW + 1)'(2));
            default:           rd_addr = n_idx;
        endcase
    end

    assign need     = (r_min_len < fed_pkg::MIN_LEN_FLOOR) ? fed_pkg::MIN_LEN_FLOOR : r_min_len;
    assign out_free = !r_out_valid || i_out_ready;

    // Status toward the controller.
    always_comb begin
        o_stat.failed      = r_in_failed;
        o_stat.is_flag     = (r_in_byte == fed_pkg::FLAG_BYTE);
        o_stat.is_esc      = (r_in_byte == fed_pkg::ESC_BYTE);
        o_stat.esc_ok      = (r_in_byte == fed_pkg::ESC_OF_ESC) ||
                             (r_in_byte == fed_pkg::ESC_OF_FLAG);
        o_stat.esc_pending = r_esc;
        o_stat.receiving   = r_receiving;
        o_stat.overflowed  = r_ovf;
        o_stat.full        = (r_fill >= FILL_MAX);
        o_stat.ge2         = (r_fill >= (AW + 1)'(2));
        o_stat.long_enough = (7'(r_fill) >= need);
        o_stat.crc_match   = ({r_hi, r_rd_data} == r_crc);
        o_stat.idx_last    = (({1'b0, r_idx} + (AW + 1)'(1)) == r_fill);
        o_stat.out_free    = out_free;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= fed_pkg::MIN_LEN_RST;
        end else if (i_cfg_we) begin
            r_min_len <= i_cfg_data;
        end
    end

    // Input transaction latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in_byte   <= i_rx_byte;
            r_in_failed <= i_read_failed;
        end
    end

    // Frame state: fill count, flags and running CRC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_receiving <= 1'b1;
            r_esc       <= 1'b0;
            r_ovf       <= 1'b0;
            r_crc       <= '0;
        end else begin
            if (i_cmd.frame_clr) begin
                r_fill      <= '0;
                r_ovf       <= 1'b0;
                r_crc       <= '0;
                r_receiving <= 1'b1;
            end else begin
                if (i_cmd.store) begin
                    r_fill <= r_fill + (AW + 1)'(1);
                end
                if (i_cmd.ovf_set) begin
                    r_ovf <= 1'b1;
                end
                if (i_cmd.crc_upd) begin
                    r_crc <= crc_step(r_crc, r_rd_data);
                end
                if (i_cmd.rcv_clr) begin
                    r_receiving <= 1'b0;
                end
            end
            if (i_cmd.esc_set) begin
                r_esc <= 1'b1;
            end else if (i_cmd.esc_clr) begin
                r_esc <= 1'b0;
            end
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_fill[AW-1:0]] <= store_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // CRC high byte capture and replay index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.hi_cap) begin
            r_hi <= r_rd_data;
        end
        r_idx <= n_idx;
    end

    // Output register: holds one result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            if (i_cmd.out_status == fed_pkg::ST_DATA) begin
                r_out_data <= r_rd_data;
                r_out_last <= o_stat.idx_last;
            end else begin
                r_out_data <= 8'h00;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_out_data;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule

// File: hw/rtl/fed_ctrl.sv
// Controller: decodes each input transaction and sequences store, check and replay.
module fed_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fed_pkg::t_dp_stat i_stat,
    output fed_pkg::t_dp_cmd  o_cmd
);
    fed_pkg::t_state  r_state;
    fed_pkg::t_state  n_state;
    fed_pkg::t_status r_emit;
    fed_pkg::t_status n_emit;
    fed_pkg::t_action action;

    // Classify the latched input byte against the frame state.
    always_comb begin
        if (i_stat.failed) begin
            action = fed_pkg::A_READ_ERR;
        end else if (i_stat.is_flag) begin
            if (i_stat.overflowed) begin
                action = fed_pkg::A_OVER;
            end else if (i_stat.long_enough) begin
                action = fed_pkg::A_CHECK;
            end else begin
                action = fed_pkg::A_DROP;
            end
        end else if (!i_stat.receiving) begin
            action = fed_pkg::A_IGNORE;
        end else if (i_stat.esc_pending && !i_stat.esc_ok) begin
            action = fed_pkg::A_FORM;
        end else if (!i_stat.esc_pending && i_stat.is_esc) begin
            action = fed_pkg::A_ESC;
        end else if (i_stat.full) begin
            action = fed_pkg::A_FULL;
        end else if (i_stat.ge2) begin
            action = fed_pkg::A_STORE_CRC;
        end else begin
            action = fed_pkg::A_STORE;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fed_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = fed_pkg::S_DECODE;
                end
            end
            fed_pkg::S_DECODE: begin
                unique case (action)
                    fed_pkg::A_READ_ERR, fed_pkg::A_OVER, fed_pkg::A_FORM:
                        n_state = fed_pkg::S_EMIT;
                    fed_pkg::A_CHECK:     n_state = fed_pkg::S_CHK1;
                    fed_pkg::A_STORE_CRC: n_state = fed_pkg::S_CRC;
                    default:              n_state = fed_pkg::S_IDLE;
                endcase
            end
            fed_pkg::S_CRC:  n_state = fed_pkg::S_IDLE;
            fed_pkg::S_CHK1: n_state = fed_pkg::S_CHK2;
            fed_pkg::S_CHK2: begin
                n_state = i_stat.crc_match ? fed_pkg::S_REPLAY : fed_pkg::S_EMIT;
            end
            fed_pkg::S_REPLAY: begin
                if (i_stat.out_free && i_stat.idx_last) begin
                    n_state = fed_pkg::S_IDLE;
                end
            end
            fed_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = fed_pkg::S_IDLE;
                end
            end
            default: n_state = fed_pkg::S_IDLE;
        endcase
    end

    // Status code held for a single-result transaction.
    always_comb begin
        n_emit = r_emit;
        if (r_state == fed_pkg::S_DECODE) begin
            case (action)
                fed_pkg::A_READ_ERR: n_emit = fed_pkg::ST_READ;
                fed_pkg::A_OVER:     n_emit = fed_pkg::ST_OVER;
                fed_pkg::A_FORM:     n_emit = fed_pkg::ST_FORM;
                default:             n_emit = r_emit;
            endcase
        end else if (r_state == fed_pkg::S_CHK2) begin
            n_emit = fed_pkg::ST_CRC;
        end
    end

    // Datapath commands.
    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_sel     = fed_pkg::RD_NEXT;
        o_cmd.out_status = fed_pkg::ST_DATA;
        o_in_ready       = 1'b0;
        unique case (r_state)
            fed_pkg::S_IDLE: begin
                // No transaction is taken while reset is held.
                o_in_ready     = i_rst_n;
                o_cmd.latch_in = i_in_valid;
            end
            fed_pkg::S_DECODE: begin
                unique case (action)
                    fed_pkg::A_READ_ERR: begin
                        o_cmd.rcv_clr = 1'b1;
                        o_cmd.esc_clr = 1'b1;
                    end
                    fed_pkg::A_OVER, fed_pkg::A_DROP: begin
                        o_cmd.frame_clr = 1'b1;
                    end
                    fed_pkg::A_CHECK: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = fed_pkg::RD_FILL1;
                    end
                    fed_pkg::A_FORM: begin
                        o_cmd.rcv_clr = 1'b1;
                        o_cmd.esc_clr = 1'b1;
                    end
                    fed_pkg::A_ESC: begin
                        o_cmd.esc_set = 1'b1;
                    end
                    fed_pkg::A_FULL: begin
                        o_cmd.ovf_set = 1'b1;
                        o_cmd.esc_clr = 1'b1;
                    end
                    fed_pkg::A_STORE: begin
                        o_cmd.store   = 1'b1;
                        o_cmd.esc_clr = 1'b1;
                    end
                    fed_pkg::A_STORE_CRC: begin
                        o_cmd.store   = 1'b1;
                        o_cmd.esc_clr = 1'b1;
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_sel  = fed_pkg::RD_FILL2;
                    end
                    default: begin
                    end
                endcase
            end
            fed_pkg::S_CRC: begin
                o_cmd.crc_upd = 1'b1;
            end
            fed_pkg::S_CHK1: begin
                o_cmd.hi_cap = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = fed_pkg::RD_FILL2;
            end
            fed_pkg::S_CHK2: begin
                if (i_stat.crc_match) begin
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                end else begin
                    o_cmd.frame_clr = 1'b1;
                end
            end
            fed_pkg::S_REPLAY: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.idx_last) begin
                        o_cmd.frame_clr = 1'b1;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        o_cmd.rd_en   = 1'b1;
                    end
                end
            end
            fed_pkg::S_EMIT: begin
                o_cmd.out_load   = i_stat.out_free;
                o_cmd.out_status = r_emit;
            end
            default: begin
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fed_pkg::S_IDLE;
            r_emit  <= fed_pkg::ST_DATA;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

endmodule

// File: hw/rtl/flag_escape_deframer_crc16_core.sv
// Top level of the byte-unstuffing deframer with CRC-16/CCITT frame check.
//
// Received bytes enter on i_in, one transaction per byte, with read_failed set
// when the serial read went wrong. 0x7e is the frame flag and 0x7d starts an
// escape. Results leave on o_out: frame bytes with status 0 and last on the
// final byte, or one status transaction (CRC, escape, read or overflow error).
// i_cfg_we/i_cfg_data write min_frame_len, the fewest bytes a frame needs (at least 3).
//
// A data byte is accepted and then decoded; once two bytes are stored, a CRC
// state follows, since the CRC is folded in from a frame store read made in the
// decode state. A flag that checks a frame reads the two CRC bytes and the first
// frame byte in the decode, CHK1 and CHK2 states, then replays one byte per cycle
// from the store's read port while the output register is free. A read, escape
// or overflow error goes from the decode state to the emit state; a CRC error
// passes CHK1 and CHK2 first. Bytes are taken one at a time.
// Results sit in an output register; when the receiver stalls, replay and
// error results wait, and no new byte is accepted until the work is done.
// Reset empties the frame, enables reception, clears the escape state and
// sets min_frame_len to 6; i_in is not ready while reset is held. The frame
// store needs no clearing pass.
module flag_escape_deframer_crc16_core #(
    parameter int unsigned MAX_FRAME = fed_pkg::MAX_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    fed_in_if.sink      i_in,
    fed_out_if.source   o_out
);
    fed_pkg::t_dp_cmd  cmd;
    fed_pkg::t_dp_stat stat;
    logic              in_ready;

    assign i_in.ready = in_ready;

    // Control state machine.
    fed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Storage, CRC and output register.
    fed_dpath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_rx_byte     (i_in.rx_byte),
        .i_read_failed (i_in.read_failed),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_data_byte   (o_out.data_byte),
        .o_status      (o_out.status),
        .o_last        (o_out.last)
    );

    // A byte is never written past the end of the frame store.
    a_no_store_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.store |-> !stat.full)
        else $error("store issued with a full frame store");

    // The output register is loaded only when its previous result has gone.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("output register overwritten");

    // The block is not ready in the cycle after it accepts a transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while previous byte in progress");

    // Replay starts only after a matching CRC.
    a_replay_on_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.idx_clr |-> stat.crc_match)
        else $error("replay started without a CRC match");

endmodule

// File: verif/tb_flag_escape_deframer_crc16_core.sv
// Self-checking testbench for the byte-unstuffing deframer with CRC-16 frame check.
`timescale 1ns / 100ps

module tb_flag_escape_deframer_crc16_core;

    localparam int unsigned FRAME_DEPTH  = fed_pkg::MAX_FRAME_DEF;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned LONG_HOLD    = 200;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned REPORT_MAX   = 10;
    localparam logic [6:0]  MIN_LEN_TOP  = 7'h7f;

    // One result transaction as it leaves the block.
    typedef struct packed {
        logic [7:0]       data_byte;
        fed_pkg::t_status status;
        logic             last;
    } t_result;

    // How the results of a directed row are known.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } t_check;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_op;

    typedef struct packed {
        t_row_op          op;
        logic [7:0]       value;
        logic             failed;
        t_check           check;
        fed_pkg::t_status status;
    } t_row;

    typedef enum logic [2:0] {
        FR_GOOD,
        FR_CORRUPT,
        FR_READ_FAIL,
        FR_BAD_ESC,
        FR_NOISE
    } t_frame_kind;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [6:0] i_cfg_data;

    fed_in_if  in_ch ();
    fed_out_if out_ch ();

    flag_escape_deframer_crc16_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Directed rows: the results are typed in where they are plain to see.
    t_row directed_rows [27] = '{
        '{ROW_ITEM, fed_pkg::FLAG_BYTE, 1'b0, CHK_NONE, fed_pkg::ST_DATA},  // empty store
        '{ROW_ITEM, 8'h00, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, 8'h00, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, 8'h00, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, fed_pkg::FLAG_BYTE, 1'b0, CHK_NONE, fed_pkg::ST_DATA},  // short frame
        '{ROW_CFG,  8'h00, 1'b0, CHK_NONE, fed_pkg::ST_DATA},  // below the floor of three
        '{ROW_ITEM, 8'h00, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, 8'h00, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, 8'h00, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, fed_pkg::FLAG_BYTE, 1'b0, CHK_MODEL, fed_pkg::ST_DATA},  // good frame
        '{ROW_ITEM, 8'hff, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, fed_pkg::ESC_BYTE, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, fed_pkg::ESC_OF_ESC, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, fed_pkg::ESC_BYTE, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, fed_pkg::ESC_OF_FLAG, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, fed_pkg::FLAG_BYTE, 1'b0, CHK_ONE, fed_pkg::ST_CRC},
        '{ROW_ITEM, fed_pkg::FLAG_BYTE, 1'b1, CHK_ONE, fed_pkg::ST_READ},  // failed read
        '{ROW_ITEM, 8'h41, 1'b0, CHK_NONE, fed_pkg::ST_DATA},  // ignored while stopped
        '{ROW_ITEM, fed_pkg::FLAG_BYTE, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, fed_pkg::ESC_BYTE, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, fed_pkg::FLAG_BYTE, 1'b0, CHK_NONE, fed_pkg::ST_DATA},  // escape survives
        '{ROW_ITEM, fed_pkg::ESC_OF_FLAG, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, 8'h12, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, 8'h34, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, fed_pkg::ESC_BYTE, 1'b0, CHK_NONE, fed_pkg::ST_DATA},
        '{ROW_ITEM, 8'h00, 1'b0, CHK_ONE, fed_pkg::ST_FORM},
        '{ROW_ITEM, fed_pkg::FLAG_BYTE, 1'b0, CHK_MODEL, fed_pkg::ST_DATA}  // kept bytes
    };

    // Deframer state as the predictor sees it.
    logic [7:0]  frame_mem [FRAME_DEPTH];
    int unsigned frame_fill  = 0;
    logic        rx_on       = 1'b1;
    logic        esc_armed   = 1'b0;
    logic        ovf_seen    = 1'b0;
    logic [15:0] crc_acc     = '0;
    logic [6:0]  min_len_reg = fed_pkg::MIN_LEN_RST;

    t_result byte_results [$];
    t_result expected_results [$];

    t_check           row_check  = CHK_MODEL;
    fed_pkg::t_status row_status = fed_pkg::ST_DATA;

    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used   = 0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;
    int unsigned status_count [5] = '{default: 0};

    int unsigned holds_asked = 0;
    int unsigned holds_done  = 0;
    int unsigned hold_left   = 0;
    int unsigned sink_gap    = 0;
    bit          sink_calm   = 1'b0;
    bit          source_calm = 1'b0;

    // One byte-wise step of CRC-16/CCITT.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] value);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]};
        c = c ^ {8'h00, value};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

    // Appends one unescaped byte to the frame, folding in the byte two places back, or marks an overflow when full.
    task automatic keep_byte(input logic [7:0] value);
        if (frame_fill >= FRAME_DEPTH) begin
            ovf_seen = 1'b1;
        end else begin
            if (frame_fill >= 2)
                crc_acc = crc16_fold(crc_acc, frame_mem[frame_fill - 2]);
            frame_mem[frame_fill] = value;
            frame_fill++;
        end
    endtask

    // Works out the results that one received byte causes.
    task automatic deframe_predict(input logic [7:0] value, input logic failed);
        int unsigned need;
        logic [15:0] tail;
        byte_results.delete();
        if (failed) begin
            rx_on = 1'b0;
            esc_armed = 1'b0;
            byte_results.push_back('{8'h00, fed_pkg::ST_READ, 1'b1});
        end else if (value == fed_pkg::FLAG_BYTE) begin
            need = (min_len_reg < fed_pkg::MIN_LEN_FLOOR) ? fed_pkg::MIN_LEN_FLOOR : min_len_reg;
            if (ovf_seen) begin
                byte_results.push_back('{8'h00, fed_pkg::ST_OVER, 1'b1});
            end else if (frame_fill >= need) begin
                tail = {frame_mem[frame_fill - 1], frame_mem[frame_fill - 2]};
                if (tail == crc_acc) begin
                    for (int unsigned i = 0; i < frame_fill; i++)
                        byte_results.push_back('{frame_mem[i], fed_pkg::ST_DATA,
                                                 i + 1 == frame_fill});
                end else begin
                    byte_results.push_back('{8'h00, fed_pkg::ST_CRC, 1'b1});
                end
            end
            frame_fill = 0;
            ovf_seen = 1'b0;
            crc_acc = '0;
            rx_on = 1'b1;
        end else if (rx_on) begin
            if (esc_armed) begin
                esc_armed = 1'b0;
                if (value == fed_pkg::ESC_OF_ESC) begin
                    keep_byte(fed_pkg::ESC_BYTE);
                end else if (value == fed_pkg::ESC_OF_FLAG) begin
                    keep_byte(fed_pkg::FLAG_BYTE);
                end else begin
                    rx_on = 1'b0;
                    byte_results.push_back('{8'h00, fed_pkg::ST_FORM, 1'b1});
                end
            end else if (value == fed_pkg::ESC_BYTE) begin
                esc_armed = 1'b1;
            end else begin
                keep_byte(value);
            end
        end
    endtask

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Compares one result transaction with the oldest expected one.
    task automatic check_result();
        t_result want;
        results_checked++;
        if (expected_results.size() == 0) begin
            note_failure($sformatf("unexpected result data %h status %0d last %b",
                                   out_ch.data_byte, out_ch.status, out_ch.last));
        end else begin
            want = expected_results.pop_front();
            status_count[want.status]++;
            if (out_ch.data_byte !== want.data_byte || out_ch.status !== want.status ||
                out_ch.last !== want.last)
                note_failure($sformatf("expected data %h status %0d last %b, got %h %0d %b",
                                       want.data_byte, want.status, want.last,
                                       out_ch.data_byte, out_ch.status, out_ch.last));
        end
    endtask

    // Both channels are watched at the rising edge; results are checked before
    // a newly accepted byte adds its own expectations.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                check_result();
            if (in_ch.valid && in_ch.ready) begin
                deframe_predict(in_ch.rx_byte, in_ch.read_failed);
                case (row_check)
                    CHK_MODEL: begin
                        foreach (byte_results[i])
                            expected_results.push_back(byte_results[i]);
                    end
                    CHK_ONE: begin
                        expected_results.push_back('{8'h00, row_status, 1'b1});
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Mostly short pauses with the odd long one.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Result ready: random stalls, calm stretches, and long hold-offs on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            out_ch.ready <= 1'b0;
            sink_gap--;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                sink_calm = !sink_calm;
            if (!sink_calm && $urandom_range(0, 2) == 0)
                sink_gap = idle_length();
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d results still expected.", expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offers one byte transaction, after an optional gap, and waits for it to be taken.
    task automatic send_byte(input logic [7:0] value, input logic failed,
                             input t_check check = CHK_MODEL,
                             input fed_pkg::t_status status = fed_pkg::ST_DATA);
        int unsigned gap;
        if ($urandom_range(0, 99) == 0)
            source_calm = !source_calm;
        gap = (!source_calm && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.rx_byte     <= value;
        in_ch.read_failed <= failed;
        row_check  = check;
        row_status = status;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        items_sent++;
    endtask

    // Stops offering and waits until every expected result is out and the block is quiet.
    task automatic settle_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [6:0] value);
        settle_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        min_len_reg = value;
        settings_used++;
    endtask

    // Payload bytes lean toward the characters that need stuffing.
    function automatic logic [7:0] frame_byte();
        if ($urandom_range(0, 5) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: return fed_pkg::FLAG_BYTE;
            1: return fed_pkg::ESC_BYTE;
            2: return fed_pkg::ESC_OF_ESC;
            default: return fed_pkg::ESC_OF_FLAG;
        endcase
    endfunction

    function automatic int unsigned frame_length();
        return ($urandom_range(0, 9) != 0) ? $urandom_range(1, 10) : $urandom_range(11, 30);
    endfunction

    function automatic t_frame_kind pick_frame_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return FR_GOOD;
        if (r < 75)
            return FR_CORRUPT;
        if (r < 83)
            return FR_READ_FAIL;
        if (r < 91)
            return FR_BAD_ESC;
        return FR_NOISE;
    endfunction

    // Sends one stuffed frame with its CRC and closing flag, or a run of noise.
    task automatic send_frame(input t_frame_kind kind, input int unsigned len,
                              input bit hold_at_flag);
        logic [7:0]  raw [$];
        logic [15:0] crc;
        logic [7:0]  value;
        int unsigned fault_at;
        crc = '0;
        if (kind == FR_NOISE) begin
            repeat (len) send_byte(frame_byte(), $urandom_range(0, 9) == 0);
            return;
        end
        repeat (len) begin
            value = frame_byte();
            raw.push_back(value);
            crc = crc16_fold(crc, value);
        end
        raw.push_back(crc[7:0]);
        raw.push_back(crc[15:8]);
        fault_at = $urandom_range(0, raw.size() - 1);
        if (kind == FR_CORRUPT)
            raw[fault_at] = raw[fault_at] ^ (8'h01 << $urandom_range(0, 7));
        foreach (raw[i]) begin
            if (i == fault_at && kind == FR_READ_FAIL)
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            if (i == fault_at && kind == FR_BAD_ESC) begin
                send_byte(fed_pkg::ESC_BYTE, 1'b0);
                do value = 8'($urandom_range(0, 255));
                while (value == fed_pkg::ESC_OF_ESC || value == fed_pkg::ESC_OF_FLAG ||
                       value == fed_pkg::FLAG_BYTE);
                send_byte(value, 1'b0);
            end
            if (raw[i] == fed_pkg::FLAG_BYTE || raw[i] == fed_pkg::ESC_BYTE) begin
                send_byte(fed_pkg::ESC_BYTE, 1'b0);
                send_byte((raw[i] == fed_pkg::FLAG_BYTE) ? fed_pkg::ESC_OF_FLAG
                                                         : fed_pkg::ESC_OF_ESC, 1'b0);
            end else begin
                send_byte(raw[i], 1'b0);
            end
        end
        if (hold_at_flag)
            holds_asked++;
        send_byte(fed_pkg::FLAG_BYTE, 1'b0);
    endtask

    task automatic run_phase(input logic [6:0] min_len, input int unsigned budget);
        int unsigned start;
        apply_setting(min_len);
        start = items_sent;
        while (items_sent - start < budget)
            send_frame(pick_frame_kind(), frame_length(), 1'b0);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.rx_byte     = '0;
        in_ch.read_failed = 1'b0;
        out_ch.ready      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows first.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG)
                apply_setting(directed_rows[i].value[6:0]);
            else
                send_byte(directed_rows[i].value, directed_rows[i].failed,
                          directed_rows[i].check, directed_rows[i].status);
        end

        // Random frames at the lowest length setting.
        run_phase(fed_pkg::MIN_LEN_FLOOR, 12);

        // A good frame replayed under a long stall while the next frame is offered,
        // and that next frame overflows the store.
        send_frame(FR_GOOD, 8, 1'b1);
        send_frame(FR_GOOD, FRAME_DEPTH - 1, 1'b0);

        // No frame is long enough to be checked here.
        run_phase(MIN_LEN_TOP, 8);
        settle_idle();

        $display("Covered %0d byte transactions and %0d result transactions over %0d settings.",
                 items_sent, results_checked, settings_used);
        $display("Results: %0d frame bytes, %0d CRC, %0d escape, %0d read, %0d overflow errors.",
                 status_count[fed_pkg::ST_DATA], status_count[fed_pkg::ST_CRC],
                 status_count[fed_pkg::ST_FORM], status_count[fed_pkg::ST_READ],
                 status_count[fed_pkg::ST_OVER]);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches found.", mismatch_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
